// File: src/signed_int_to_decimal_ascii_core_assert.svh
// Assertion macros used by the decimal text converter RTL.
// Expects signals clk and arst_n in the scope of each use.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SIDASC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SIDASC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/sidasc_pkg.sv
// Shared constants and helpers for the signed integer to decimal text converter.
// No dependencies.
package sidasc_pkg;

	// Default width of the input integer
	localparam int VALUE_WIDTH_DEF = 32;

	// Character and digit encoding
	localparam int CHAR_W  = 6;
	localparam int DIGIT_W = 4;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	// Double-dabble correction: digits of five or more get three added
	localparam logic [DIGIT_W-1:0] DABBLE_LIMIT  = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADJUST = 4'd3;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX     = 4'd9;

	// Shift steps done by one pipeline stage
	localparam int STEPS_PER_STAGE = 8;

	// Decimal digits that cover any unsigned value of w bits (1233/4096 ~ log10 2)
	function automatic int num_digits(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

	// Number of dabble stages for w bits
	function automatic int num_stages(input int w);
		return (w + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	endfunction

endpackage

// File: src/sidasc_dabble_stage.sv
// One registered stage of the binary to BCD shift-and-add-three converter.
// Depends on sidasc_pkg.
module sidasc_dabble_stage #(
	parameter int VALUE_WIDTH = sidasc_pkg::VALUE_WIDTH_DEF,
	parameter int NDIG        = sidasc_pkg::num_digits(sidasc_pkg::VALUE_WIDTH_DEF),
	parameter int FIRST_STEP  = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	output logic                                  in_rdy,
	input  logic                                  in_neg,
	input  logic [NDIG*sidasc_pkg::DIGIT_W-1:0]   in_bcd,
	input  logic [VALUE_WIDTH-1:0]                in_bin,
	output logic                                  out_vld,
	input  logic                                  out_rdy,
	output logic                                  out_neg,
	output logic [NDIG*sidasc_pkg::DIGIT_W-1:0]   out_bcd,
	output logic [VALUE_WIDTH-1:0]                out_bin
);

	localparam int DW     = sidasc_pkg::DIGIT_W;
	localparam int BCD_W  = NDIG * DW;
	localparam int REMAIN = VALUE_WIDTH - FIRST_STEP;
	localparam int STEPS  = (REMAIN > sidasc_pkg::STEPS_PER_STAGE) ?
		sidasc_pkg::STEPS_PER_STAGE : REMAIN;

	// _s2 registers: output of this dabble stage
	logic                 vld_s2;
	logic                 neg_s2;
	logic [BCD_W-1:0]     bcd_s2;
	logic [VALUE_WIDTH-1:0] bin_s2;

	logic [BCD_W-1:0]     bcd_v;
	logic [VALUE_WIDTH-1:0] bin_v;

	// Shift-and-add-three over this stage's bits
	always_comb begin
		bcd_v = in_bcd;
		bin_v = in_bin;
		for (int k = 0; k < STEPS; k++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_v[d*DW +: DW] >= sidasc_pkg::DABBLE_LIMIT) begin
					bcd_v[d*DW +: DW] = bcd_v[d*DW +: DW] + sidasc_pkg::DABBLE_ADJUST;
				end
			end
			{bcd_v, bin_v} = {bcd_v[BCD_W-2:0], bin_v, 1'b0};
		end
	end

	// Stage moves when empty or when downstream takes its contents
	assign in_rdy = !vld_s2 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_rdy) begin
			vld_s2 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			neg_s2 <= in_neg;
			bcd_s2 <= bcd_v;
			bin_s2 <= bin_v;
		end
	end

	assign out_vld = vld_s2;
	assign out_neg = neg_s2;
	assign out_bcd = bcd_s2;
	assign out_bin = bin_s2;

endmodule

// File: src/sidasc_emit.sv
// Character serializer: suppresses leading zeros and sends sign and digits.
// Depends on sidasc_pkg and signed_int_to_decimal_ascii_core_assert.svh.
`include "signed_int_to_decimal_ascii_core_assert.svh"

module sidasc_emit #(
	parameter int NDIG = sidasc_pkg::num_digits(sidasc_pkg::VALUE_WIDTH_DEF)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	output logic                                in_rdy,
	input  logic                                in_neg,
	input  logic [NDIG*sidasc_pkg::DIGIT_W-1:0] in_bcd,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,   // [5:0] character, [7:6] zero
	output logic                                m_tlast
);

	localparam int DW    = sidasc_pkg::DIGIT_W;
	localparam int BCD_W = NDIG * DW;
	localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

	logic              busy_q;
	logic              neg_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BCD_W-1:0]  digits_q;

	logic [IDX_W-1:0]  top_idx;
	logic [DW-1:0]     digit;
	logic              fire;
	logic              is_last;
	logic              load;
	logic [sidasc_pkg::CHAR_W-1:0] char_v;

	// Highest nonzero digit of the incoming request, zero if all are zero
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < NDIG; d++) begin
			if (in_bcd[d*DW +: DW] != '0) begin
				top_idx = IDX_W'(d);
			end
		end
	end

	assign digit   = digits_q[idx_q*DW +: DW];
	assign fire    = m_tvalid && m_tready;
	assign is_last = !neg_q && (idx_q == '0);
	assign in_rdy  = !busy_q || (fire && is_last);
	assign load    = in_vld && in_rdy;

	// Sign first, then digits from the top down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			neg_q  <= in_neg;
			idx_q  <= top_idx;
		end else if (fire) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= in_bcd;
		end
	end

	// Output character
	always_comb begin
		if (neg_q) begin
			char_v = sidasc_pkg::CHAR_MINUS;
		end else begin
			char_v = sidasc_pkg::CHAR_ZERO + {{(sidasc_pkg::CHAR_W-DW){1'b0}}, digit};
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {{(8-sidasc_pkg::CHAR_W){1'b0}}, char_v};
	assign m_tlast  = is_last;

	// Text continues after a non-final character
	`SIDASC_ASSERT_NEXT(a_text_continues, fire && !is_last, m_tvalid, "text cut short")
	// Every digit sent is a valid decimal digit
	`SIDASC_ASSERT_NOW(a_digit_bcd, busy_q && !neg_q, digit <= sidasc_pkg::DIGIT_MAX,
		"digit out of range")
	// First digit of a number is nonzero unless it is the only one
	`SIDASC_ASSERT_NEXT(a_no_lead_zero, load, (digit != '0) || (idx_q == '0),
		"leading zero sent")

endmodule

// File: src/signed_int_to_decimal_ascii_core.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sidasc_pkg, sidasc_dabble_stage and sidasc_emit.
//
// Each request on the slave side carries one two's complement integer; the master side
// returns its decimal text as ASCII characters, most significant first, a leading '-'
// for negative values, no leading zeros, a single '0' for zero, and tlast on the final
// character. A request passes a sign/magnitude register, then ceil(VALUE_WIDTH/8)
// shift-and-add-three stages (up to eight bits each), then the character serializer,
// which registers it before presenting its first character on the master side. The
// serializer sends one character per cycle over the single output port while m_tready
// is high, so a number of n characters (1 to 11 at 32 bits) holds the port until all n
// are taken, and the next request's first character can follow its last one directly.
// The pipeline keeps accepting requests while the serializer is busy until its stages
// are full.
module signed_int_to_decimal_ascii_core #(
	parameter int VALUE_WIDTH = sidasc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   s_tdata,   // [VALUE_WIDTH-1:0] value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,   // [5:0] character
	output logic                               m_tlast    // last
);

	localparam int NDIG  = sidasc_pkg::num_digits(VALUE_WIDTH);
	localparam int BCD_W = NDIG * sidasc_pkg::DIGIT_W;
	localparam int NST   = sidasc_pkg::num_stages(VALUE_WIDTH);

	// Stage 1: sign and magnitude (most negative value fits unsigned)
	logic                   vld_s1;
	logic                   neg_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;
	logic [VALUE_WIDTH-1:0] value_v;

	// Links between stages: index 0 is stage 1's output
	logic                   vld_l [NST+1];
	logic                   rdy_l [NST+1];
	logic                   neg_l [NST+1];
	logic [BCD_W-1:0]       bcd_l [NST+1];
	logic [VALUE_WIDTH-1:0] bin_l [NST+1];

	assign value_v  = s_tdata[VALUE_WIDTH-1:0];
	assign s_tready = !vld_s1 || rdy_l[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			neg_s1 <= value_v[VALUE_WIDTH-1];
			mag_s1 <= value_v[VALUE_WIDTH-1] ? (~value_v + 1'b1) : value_v;
		end
	end

	assign vld_l[0] = vld_s1;
	assign neg_l[0] = neg_s1;
	assign bcd_l[0] = '0;
	assign bin_l[0] = mag_s1;

	// Binary to BCD stages
	for (genvar i = 0; i < NST; i++) begin : g_dabble
		sidasc_dabble_stage #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.NDIG        (NDIG),
			.FIRST_STEP  (i * sidasc_pkg::STEPS_PER_STAGE)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vld_l[i]),
			.in_rdy  (rdy_l[i]),
			.in_neg  (neg_l[i]),
			.in_bcd  (bcd_l[i]),
			.in_bin  (bin_l[i]),
			.out_vld (vld_l[i+1]),
			.out_rdy (rdy_l[i+1]),
			.out_neg (neg_l[i+1]),
			.out_bcd (bcd_l[i+1]),
			.out_bin (bin_l[i+1])
		);
	end

	// Character serializer
	sidasc_emit #(
		.NDIG (NDIG)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_l[NST]),
		.in_rdy   (rdy_l[NST]),
		.in_neg   (neg_l[NST]),
		.in_bcd   (bcd_l[NST]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
